### rtl/lph_pkg.sv
// Shared types and codes for the linear-probe hash map.
package lph_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CNT_OUT_W = 7;
  localparam int CFG_W  = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // multiplicative hash constant
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  localparam logic [CFG_W-1:0] MAX_OCC_RESET = 7'd47;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_OCC = 1'b0;

  localparam logic [1:0] ACT_PUT    = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  typedef logic [1:0] mark_t;
  localparam mark_t MARK_EMPTY = 2'd0;
  localparam mark_t MARK_LIVE  = 2'd1;
  localparam mark_t MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [VAL_W-1:0]     read_value;
    logic [CNT_OUT_W-1:0] live_count;
  } rsp_t;

  // slot store write controls
  typedef struct packed {
    logic             mark_en;
    mark_t            mark;
    logic             key_en;
    logic             value_en;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_wr_t;

endpackage

### rtl/lph_hash.sv
// Registered multiplicative hash: home slot from the top bits of key * constant.
module lph_hash import lph_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic [KEY_W-1:0] key,
  output logic [IDX_W-1:0] home
);

  logic [31:0] prod;

  // low 32 bits of the product only
  assign prod = key * HASH_MULT;

  always_ff @(posedge clk) begin
    home <= prod[31 -: IDX_W];
  end

endmodule

### rtl/lph_slot_ram.sv
// Slot store: mark, key and value arrays, one write port, one registered read port.
module lph_slot_ram import lph_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_wr_t          wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output mark_t             rd_mark,
  output logic [KEY_W-1:0]  rd_key,
  output logic [VAL_W-1:0]  rd_value
);

  mark_t            mark_mem  [DEPTH];
  logic [KEY_W-1:0] key_mem   [DEPTH];
  logic [VAL_W-1:0] value_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && wr.mark_en) begin
      mark_mem[wr_addr] <= wr.mark;
    end
    if (wr_en && wr.key_en) begin
      key_mem[wr_addr] <= wr.key;
    end
    if (wr_en && wr.value_en) begin
      value_mem[wr_addr] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_mark  <= mark_mem[rd_addr];
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

### rtl/linear_probe_hash_map_core.sv
// Linear-probe hash map top level: sequencer, counters, config register, response register.
// Put/get/remove: S_HASH, S_HOME, S_PROBE over P = slots probed (1..CAPACITY), one slot per
//   cycle via the single slot-store read port; S_FIN commits when the response register is free.
// Clear sweeps the mark store one slot per cycle in S_CLR, then commits from S_FIN.
// Throughput: one item at a time; req_ready is high only while the sequencer is idle.
// Reset: synchronous; after reset a clearing pass empties every slot with
//   req_ready low (config writes still taken); max_occupied resets to 47.
module linear_probe_hash_map_core import lph_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  // sequencer codes
  localparam logic [2:0] S_CLR   = 3'd0;  // sweep marks to empty
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;  // multiplier working
  localparam logic [2:0] S_HOME  = 3'd3;  // issue read of home slot
  localparam logic [2:0] S_PROBE = 3'd4;  // one slot checked per cycle
  localparam logic [2:0] S_FIN   = 3'd5;  // commit and load response

  logic [2:0]       state;

  // latched request
  logic [1:0]       act_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;

  // probe bookkeeping
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] cnt;
  logic             seen_tomb;
  logic [IDX_W-1:0] tomb_idx;
  logic             found;
  logic             have;
  logic             tomb;
  logic [IDX_W-1:0] slot;
  logic [VAL_W-1:0] rd_val;
  logic             clr_resp;

  logic [CNT_W-1:0] live_entries;
  logic [CNT_W-1:0] used_slots;
  logic [CFG_W-1:0] max_occupied;

  // hash and slot store
  logic [IDX_W-1:0] home;
  logic [IDX_W-1:0] rd_addr;
  mark_t            rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_value;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_wr_t         wr;

  // probe decode
  logic             is_empty;
  logic             is_tomb;
  logic             key_hit;
  logic             last;

  // commit decode
  logic             commit;
  logic             ins_ok;
  logic [2:0]       status_next;
  logic [VAL_W-1:0] read_next;
  logic [CNT_W-1:0] live_next;
  logic [CNT_W-1:0] used_next;
  logic [CMP_W-1:0] live_ext;

  lph_hash #(.IDX_W(IDX_W)) u_hash (
    .clk  (clk),
    .key  (key_r),
    .home (home)
  );

  lph_slot_ram #(.DEPTH(CAPACITY), .ADDR_W(IDX_W)) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_mark  (rd_mark),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // ---------------- config port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_occupied <= MAX_OCC_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_OCC)) begin
      max_occupied <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_OCC) ? PDATA_W'(max_occupied) : '0;

  // ---------------- probe decode ----------------
  assign req_ready = (state == S_IDLE);
  assign idx_inc   = idx + IDX_W'(1);
  // next read: home slot on the first probe, then the following slot (wraps)
  assign rd_addr   = (state == S_HOME) ? home : idx_inc;

  assign is_empty = (rd_mark == MARK_EMPTY);
  assign is_tomb  = (rd_mark == MARK_TOMB);
  assign key_hit  = (rd_mark == MARK_LIVE) && (rd_key == key_r);
  assign last     = (cnt == {IDX_W{1'b1}});

  // ---------------- commit decode ----------------
  // response register must be free before anything is committed
  assign commit = (state == S_FIN) && (!rsp_valid || rsp_ready);
  assign ins_ok = have && (tomb || (CMP_W'(used_slots) < CMP_W'(max_occupied)));

  always_comb begin
    status_next   = ST_NOT_FOUND;
    read_next     = '0;
    live_next     = live_entries;
    used_next     = used_slots;
    wr            = '0;
    wr.key        = key_r;
    wr.value      = value_r;
    wr_en         = 1'b0;
    if (state == S_CLR) begin
      wr_en      = 1'b1;
      wr.mark_en = 1'b1;
      wr.mark    = MARK_EMPTY;
    end else if (act_r == ACT_CLEAR) begin
      status_next = ST_CLEARED;
      live_next   = '0;
      used_next   = '0;
    end else if (found) begin
      status_next = ST_FOUND;
      unique case (act_r)
        ACT_PUT: begin
          wr_en       = commit;
          wr.value_en = 1'b1;
        end
        ACT_REMOVE: begin
          read_next  = rd_val;
          wr_en      = commit;
          wr.mark_en = 1'b1;
          wr.mark    = MARK_TOMB;
          live_next  = live_entries - CNT_W'(1);
        end
        default: begin
          read_next = rd_val;
        end
      endcase
    end else if (act_r == ACT_PUT) begin
      if (ins_ok) begin
        status_next = ST_INSERTED;
        wr_en       = commit;
        wr.mark_en  = 1'b1;
        wr.mark     = MARK_LIVE;
        wr.key_en   = 1'b1;
        wr.value_en = 1'b1;
        live_next   = live_entries + CNT_W'(1);
        used_next   = tomb ? used_slots : used_slots + CNT_W'(1);
      end else begin
        status_next = ST_FULL;
      end
    end
  end

  assign wr_addr  = (state == S_CLR) ? idx : slot;
  assign live_ext = CMP_W'(live_next);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      idx          <= '0;
      cnt          <= '0;
      clr_resp     <= 1'b0;
      seen_tomb    <= 1'b0;
      found        <= 1'b0;
      have         <= 1'b0;
      tomb         <= 1'b0;
      live_entries <= '0;
      used_slots   <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          idx <= idx_inc;
          if (idx == {IDX_W{1'b1}}) begin
            state <= clr_resp ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            idx      <= '0;
            clr_resp <= (req.action == ACT_CLEAR);
            found    <= 1'b0;
            state    <= (req.action == ACT_CLEAR) ? S_CLR : S_HASH;
          end
        end
        S_HASH: begin
          state <= S_HOME;
        end
        S_HOME: begin
          idx       <= home;
          cnt       <= '0;
          seen_tomb <= 1'b0;
          state     <= S_PROBE;
        end
        S_PROBE: begin
          priority if (is_empty) begin
            found <= 1'b0;
            have  <= 1'b1;
            tomb  <= seen_tomb;
            state <= S_FIN;
          end else if (key_hit) begin
            found <= 1'b1;
            state <= S_FIN;
          end else if (last) begin
            // every slot visited: only a tombstone can take a new key
            found <= 1'b0;
            have  <= seen_tomb || is_tomb;
            tomb  <= seen_tomb || is_tomb;
            state <= S_FIN;
          end else begin
            idx <= idx_inc;
            cnt <= cnt + IDX_W'(1);
          end
          if (is_tomb && !seen_tomb) begin
            seen_tomb <= 1'b1;
          end
        end
        S_FIN: begin
          if (commit) begin
            live_entries <= live_next;
            used_slots   <= used_next;
            clr_resp     <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      act_r   <= req.action;
      key_r   <= req.key;
      value_r <= req.value;
    end
    if (state == S_PROBE) begin
      if (is_tomb && !seen_tomb) begin
        tomb_idx <= idx;
      end
      priority if (is_empty || (!key_hit && last)) begin
        slot <= seen_tomb ? tomb_idx : idx;
      end else if (key_hit) begin
        slot   <= idx;
        rd_val <= rd_value;
      end else begin
        slot <= slot;
      end
    end
  end

  // ---------------- response register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.status     <= status_next;
      rsp.read_value <= read_next;
      rsp.live_count <= live_ext[CNT_OUT_W-1:0];
    end
  end

  // ---------------- assertions ----------------
  a_live_le_used: assert property (@(posedge clk) disable iff (rst)
    live_entries <= used_slots)
    else $error("live entries exceed used slots");

  a_used_le_cap: assert property (@(posedge clk) disable iff (rst)
    used_slots <= CNT_W'(CAPACITY))
    else $error("used slots exceed capacity");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) && last |=> (state != S_PROBE))
    else $error("probe ran past a full lap");

  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid && (state == S_IDLE))
    else $error("commit did not produce a response beat");

endmodule
